// ===== sv/dtv_pkg.sv =====
// Shared constants, types and codes for the DER TLV stream validator.
`default_nettype none
package dtv_pkg;

	// Sizing of the nesting stack and of the byte offsets.
	localparam int MAX_DEPTH = 16;
	localparam int POS_WIDTH = 33;
	localparam int LEN_W     = 32;
	localparam int DEP_W     = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int SUM_W     = ((POS_WIDTH > LEN_W) ? POS_WIDTH : LEN_W) + 1;
	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

	// Header byte constants.
	localparam logic [7:0] LEN_LONG      = 8'h80;
	localparam logic [7:0] LEN_LONG_MIN  = 8'h81;
	localparam logic [7:0] LEN_LONG_MAX  = 8'h84;
	localparam logic [7:0] TAG_CONS_LO   = 8'h30;
	localparam logic [7:0] TAG_CONS_HI   = 8'h40;

	// Header parse phase.
	typedef enum logic [2:0] {
		PH_TAG  = 3'b001,
		PH_LEN  = 3'b010,
		PH_LONG = 3'b100
	} phase_t;

	// Sticky error codes.
	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_CUT    = 3'd1,
		ERR_FORM   = 3'd2,
		ERR_EXCEED = 3'd3,
		ERR_DEEP   = 3'd4,
		ERR_TRUNC  = 3'd5
	} err_t;

	// Message status codes.
	typedef enum logic [1:0] {
		STAT_BUSY  = 2'd0,
		STAT_VALID = 2'd1,
		STAT_ERROR = 2'd2
	} stat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic pop;
		logic load_top;
		logic exec;
	} dtv_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pop_need;
		logic pop_rd;
	} dtv_sts_t;

endpackage
`default_nettype wire

// ===== sv/dtv_ctrl.sv =====
// Controller state machine of the DER TLV stream validator.
`default_nettype none
module dtv_ctrl
	import dtv_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dtv_sts_t sts,
	output dtv_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CHECK = 3'b010,
		ST_LOAD  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.pop_need) begin
					cmd.pop = 1'b1;
					if (sts.pop_rd) begin
						state_nxt = ST_LOAD;
					end
				end else if (!out_valid_q || out_ready) begin
					cmd.exec  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_LOAD: begin
				cmd.load_top = 1'b1;
				state_nxt    = ST_CHECK;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// The result register is full from its load until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== sv/dtv_dpath.sv =====
// Datapath of the DER TLV stream validator: parse state, level stack, result register.
`default_nettype none
module dtv_dpath
	import dtv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic       is_last,
	input  wire dtv_cmd_t   cmd,
	output dtv_sts_t        sts,
	output logic            header_valid,
	output logic [7:0]      elem_tag,
	output logic [31:0]     elem_length,
	output logic [4:0]      elem_depth,
	output logic [1:0]      status,
	output logic [2:0]      error_code
);

	// Captured input byte.
	logic [7:0]           byte_q;
	logic                 last_q;

	// Parse state.
	phase_t               phase_q;
	logic [7:0]           tag_q;
	logic [LEN_W-1:0]     lacc_q;
	logic [2:0]           left_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH-1:0] prim_q;
	logic [DEP_W-1:0]     depth_q;
	err_t                 err_q;

	// Cached innermost and outermost open-level ends, and the stack memory.
	logic [POS_WIDTH-1:0] top_q;
	logic [POS_WIDTH-1:0] bot_q;
	logic [POS_WIDTH-1:0] rd_q;
	logic [POS_WIDTH-1:0] stack_mem [MAX_DEPTH];
	logic [IDX_W-1:0]     rd_addr;

	// Next values from one byte step.
	phase_t               phase_n;
	logic [7:0]           tag_n;
	logic [LEN_W-1:0]     lacc_n;
	logic [2:0]           left_n;
	logic [POS_WIDTH-1:0] pos_n;
	logic [POS_WIDTH-1:0] prim_n;
	logic [DEP_W-1:0]     depth_n;
	err_t                 err_n;
	logic [POS_WIDTH-1:0] top_n;
	logic [POS_WIDTH-1:0] bot_n;
	logic                 push;
	logic [POS_WIDTH-1:0] end_pos;
	logic                 hv_n;
	logic [1:0]           stat_n;

	// Outgoing result register.
	logic                 hv_q;
	logic [7:0]           otag_q;
	logic [LEN_W-1:0]     olen_q;
	logic [4:0]           odep_q;
	logic [1:0]           stat_q;
	err_t                 ocode_q;

	// A level closes before a tag byte when its end is at or before this offset.
	assign sts.pop_need = (err_q == ERR_NONE) && (pos_q != POS_MAX) && (phase_q == PH_TAG)
		&& (pos_q >= prim_q) && (depth_q != '0) && (top_q <= pos_q);
	assign sts.pop_rd   = (depth_q > DEP_W'(1));
	assign rd_addr      = IDX_W'(depth_q - DEP_W'(2));

	// One byte step of the header parser.
	always_comb begin
		logic             done;
		logic             cut;
		logic [2:0]       left_dec;
		logic [SUM_W-1:0] end_sum;
		logic             open_lvl;

		phase_n  = phase_q;
		tag_n    = tag_q;
		lacc_n   = lacc_q;
		left_n   = left_q;
		prim_n   = prim_q;
		depth_n  = depth_q;
		err_n    = err_q;
		top_n    = top_q;
		bot_n    = bot_q;
		push     = 1'b0;
		hv_n     = 1'b0;
		done     = 1'b0;
		left_dec = '0;
		open_lvl = 1'b0;
		cut      = (depth_q != '0) && (pos_q >= top_q);
		end_sum  = '0;
		end_pos  = '0;

		if ((err_q == ERR_NONE) && (pos_q == POS_MAX)) begin
			err_n = ERR_EXCEED;
		end

		if (err_n == ERR_NONE) begin
			unique case (phase_q)
				PH_TAG: begin
					if (pos_q >= prim_q) begin
						tag_n   = byte_q;
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					if (cut) begin
						err_n = ERR_CUT;
					end else if (byte_q < LEN_LONG) begin
						lacc_n = LEN_W'(byte_q);
						done   = 1'b1;
					end else if (byte_q >= LEN_LONG_MIN && byte_q <= LEN_LONG_MAX) begin
						lacc_n  = '0;
						left_n  = 3'(byte_q - LEN_LONG);
						phase_n = PH_LONG;
					end else begin
						err_n = ERR_FORM;
					end
				end
				PH_LONG: begin
					if (cut) begin
						err_n = ERR_CUT;
					end else begin
						lacc_n   = {lacc_q[LEN_W-9:0], byte_q};
						left_dec = (left_q != '0) ? left_q - 3'd1 : 3'd0;
						left_n   = left_dec;
						done     = (left_dec == '0);
					end
				end
				default: begin
					err_n = err_q;
				end
			endcase

			// A completed header opens a level or a primitive skip.
			if (done) begin
				end_sum = SUM_W'(pos_q) + SUM_W'(1) + SUM_W'(lacc_n);
				end_pos = end_sum[POS_WIDTH-1:0];
				phase_n = PH_TAG;
				hv_n    = 1'b1;
				if (end_sum > SUM_W'(POS_MAX)) begin
					err_n = ERR_EXCEED;
				end else if ((depth_q != '0) && (end_pos > top_q)) begin
					err_n = ERR_EXCEED;
				end else if (tag_q >= TAG_CONS_LO && tag_q < TAG_CONS_HI) begin
					if (depth_q >= DEP_W'(MAX_DEPTH)) begin
						err_n = ERR_DEEP;
					end else begin
						push    = 1'b1;
						top_n   = end_pos;
						depth_n = depth_q + DEP_W'(1);
						if (depth_q == '0) begin
							bot_n = end_pos;
						end
					end
				end else begin
					prim_n = end_pos;
				end
			end
		end

		pos_n  = (pos_q != POS_MAX) ? pos_q + POS_WIDTH'(1) : pos_q;
		stat_n = (err_n != ERR_NONE) ? STAT_ERROR : STAT_BUSY;

		// Verdict on the final byte; the stack is nested, so its bottom end is the largest.
		if (last_q) begin
			if (err_n == ERR_NONE) begin
				open_lvl = (phase_n != PH_TAG) || (prim_n > pos_n)
					|| ((depth_n != '0) && (bot_n > pos_n));
				if (open_lvl) begin
					err_n = ERR_TRUNC;
				end
			end
			stat_n = (err_n != ERR_NONE) ? STAT_ERROR : STAT_VALID;
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= data_byte;
			last_q <= is_last;
		end
	end

	// Parse state, cleared again after the final byte of a message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q   <= '0;
			lacc_q  <= '0;
			left_q  <= '0;
			pos_q   <= '0;
			prim_q  <= '0;
			depth_q <= '0;
			err_q   <= ERR_NONE;
			top_q   <= '0;
			bot_q   <= '0;
		end else if (cmd.exec) begin
			if (last_q) begin
				phase_q <= PH_TAG;
				tag_q   <= '0;
				lacc_q  <= '0;
				left_q  <= '0;
				pos_q   <= '0;
				prim_q  <= '0;
				depth_q <= '0;
				err_q   <= ERR_NONE;
			end else begin
				phase_q <= phase_n;
				tag_q   <= tag_n;
				lacc_q  <= lacc_n;
				left_q  <= left_n;
				pos_q   <= pos_n;
				prim_q  <= prim_n;
				depth_q <= depth_n;
				err_q   <= err_n;
				top_q   <= top_n;
				bot_q   <= bot_n;
			end
		end else if (cmd.pop) begin
			depth_q <= depth_q - DEP_W'(1);
		end else if (cmd.load_top) begin
			top_q <= rd_q;
		end
	end

	// Level stack memory: push on a new constructed element, read the next level on a pop.
	always_ff @(posedge clk) begin
		if (cmd.exec && push && !last_q) begin
			stack_mem[depth_q[IDX_W-1:0]] <= end_pos;
		end
		if (cmd.pop && sts.pop_rd) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			hv_q    <= hv_n;
			otag_q  <= hv_n ? tag_q : 8'd0;
			olen_q  <= hv_n ? lacc_n : '0;
			odep_q  <= hv_n ? 5'(depth_q) : 5'd0;
			stat_q  <= stat_n;
			ocode_q <= err_n;
		end
	end

	assign header_valid = hv_q;
	assign elem_tag     = otag_q;
	assign elem_length  = olen_q;
	assign elem_depth   = odep_q;
	assign status       = stat_q;
	assign error_code   = ocode_q;

endmodule
`default_nettype wire

// ===== sv/der_tlv_stream_validator.sv =====
// Top level of the DER TLV stream validator.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    data_byte, is_last
//  out      source     out_valid/out_ready  header_valid, elem_tag, elem_length,
//                                           elem_depth, status, error_code
//
// Each byte is first captured and then run through the header parser.
// Closing a nested level before a tag byte adds a pop step, and when an outer level
// stays open also a load step that takes its end from the registered read port of the level stack memory.
// The result register holds one finished transaction; a new byte is taken while it waits.
// A stalled output holds the parser step until the result register frees up.
// Reset leaves the block ready for the first byte of a message; it needs no clearing pass.
`default_nettype none
module der_tlv_stream_validator
	import dtv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             header_valid,
	output logic [7:0]       elem_tag,
	output logic [31:0]      elem_length,
	output logic [4:0]       elem_depth,
	output logic [1:0]       status,
	output logic [2:0]       error_code
);

	dtv_cmd_t cmd;
	dtv_sts_t sts;

	// Sequencing of capture, level closing and the parser step.
	dtv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Parser state, level stack and result register.
	dtv_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.is_last      (is_last),
		.cmd          (cmd),
		.sts          (sts),
		.header_valid (header_valid),
		.elem_tag     (elem_tag),
		.elem_length  (elem_length),
		.elem_depth   (elem_depth),
		.status       (status),
		.error_code   (error_code)
	);

endmodule
`default_nettype wire
